// ===== src/nsr_pkg.sv =====
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared widths, constants and control types for the Newton square root core.
// ----------------------------------------------------------------------------
package nsr_pkg;

    // field widths
    localparam int VALUE_W = 32;
    localparam int GUESS_W = 32;
    localparam int ROOT_W  = 24;
    localparam int TOL_W   = 16;
    localparam int STEP_W  = 6;

    // largest root that fits the result field
    localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};

    // sequencer to divider
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    // divider to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== src/nsr_divider.sv =====
// ----------------------------------------------------------------------------
// nsr_divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nsr_divider #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  nsr_pkg::div_ctrl_t ctrl,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    output nsr_pkg::div_stat_t stat,
    output logic [NUM_W-1:0]   quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] qr_reg;

    // trial subtract of the shifted partial remainder
    logic [DEN_W:0] shifted;
    logic [DEN_W:0] trial;
    logic           ge;

    assign shifted = {rem_reg, qr_reg[NUM_W-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign ge      = ~trial[DEN_W];

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                cnt_reg <= CNT_W'(NUM_W);
                run_reg <= 1'b1;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: numerator shifts out the top while quotient bits shift in
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            qr_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (run_reg) begin
            qr_reg  <= {qr_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign quot      = qr_reg;

endmodule

// ===== src/newton_square_root_core.sv =====
// ----------------------------------------------------------------------------
// newton_square_root_core
// Square root of a signed fixed-point word by Newton iteration, using one
// shared bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | content
//  --------+-----+----------------------+--------------------------------------
//  s_      | in  | s_tvalid / s_tready  | tdata[31:0] value (signed fixed)
//  m_      | out | m_tvalid / m_tready  | tdata[23:0] root, tuser[0] invalid
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_data[15:0] tolerance
//
//  Negative, zero and one words go from idle straight to the done state, skipping the divider.
//  Other words run steps through the bit-serial divider, each followed by a check;
//  at most MAX_STEPS steps, fewer with a wider tolerance.
//  s_tready is high only while the sequencer is idle; a finished result sits in the
//  output register, so the next word can be taken while it waits.
//  aresetn is synchronous; it clears the sequencer and output valid, tolerance to 1.
//
module newton_square_root_core #(
    parameter int FRAC_BITS = 16,
    parameter int MAX_STEPS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] value
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [23:0] root
    output logic        m_tuser,    // [0] invalid
    // tolerance register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int NUM_W = nsr_pkg::GUESS_W + FRAC_BITS;
    localparam logic [nsr_pkg::GUESS_W-1:0] ONE_VAL = nsr_pkg::GUESS_W'(1) << FRAC_BITS;
    localparam logic [nsr_pkg::STEP_W-1:0] STEP_CAP = nsr_pkg::STEP_W'(MAX_STEPS);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_START = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [nsr_pkg::TOL_W-1:0]   tol_reg;
    logic [nsr_pkg::GUESS_W-1:0] guess_reg;
    logic [nsr_pkg::GUESS_W-1:0] new_guess_reg;
    logic [nsr_pkg::STEP_W-1:0]  step_reg;
    logic                        inv_reg;
    logic                        out_valid_reg;
    logic [nsr_pkg::ROOT_W-1:0]  out_root_reg;
    logic                        out_inv_reg;

    // operand held for all steps
    logic [nsr_pkg::VALUE_W-1:0] s_value_reg;

    nsr_pkg::div_ctrl_t div_ctrl;
    nsr_pkg::div_stat_t div_stat;
    logic [NUM_W-1:0]   quot;

    logic s_accept;
    logic special;
    logic out_free;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign special   = s_tdata[31] || (s_tdata == '0) || (s_tdata == ONE_VAL);

    // shared divider: (value << FRAC_BITS) / guess
    assign div_ctrl.start = (state_reg == ST_START);

    nsr_divider #(
        .NUM_W (NUM_W),
        .DEN_W (nsr_pkg::GUESS_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .num     ({s_value_reg, {FRAC_BITS{1'b0}}}),
        .den     (guess_reg),
        .stat    (div_stat),
        .quot    (quot)
    );

    // next guess = (g + q) / 2, saturated to the guess width
    logic [NUM_W:0]   sum;
    logic [NUM_W-1:0] half;
    logic [nsr_pkg::GUESS_W-1:0] half_sat;

    assign sum      = {(NUM_W + 1 - nsr_pkg::GUESS_W)'(0), guess_reg} + {1'b0, quot};
    assign half     = sum[NUM_W:1];
    assign half_sat = (|half[NUM_W-1:nsr_pkg::GUESS_W]) ? {nsr_pkg::GUESS_W{1'b1}}
                                                        : half[nsr_pkg::GUESS_W-1:0];

    // convergence test
    logic [nsr_pkg::GUESS_W-1:0] diff;
    logic                        stop;

    assign diff = (new_guess_reg >= guess_reg) ? new_guess_reg - guess_reg
                                               : guess_reg - new_guess_reg;
    assign stop = (diff <= {(nsr_pkg::GUESS_W - nsr_pkg::TOL_W)'(0), tol_reg})
               || (step_reg >= STEP_CAP)
               || (new_guess_reg == '0);

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) state_next = special ? ST_DONE : ST_START;
            end
            ST_START: state_next = ST_DIV;
            ST_DIV: begin
                if (div_stat.done) state_next = ST_CHECK;
            end
            ST_CHECK: state_next = stop ? ST_DONE : ST_START;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tol_reg   <= nsr_pkg::TOL_W'(1);
        end else begin
            state_reg <= state_next;
            if (cfg_valid) tol_reg <= cfg_data;
        end
    end

    // iteration datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    s_value_reg <= s_tdata;
                    step_reg    <= '0;
                    inv_reg     <= s_tdata[31];
                    guess_reg   <= s_tdata[31] ? '0 : s_tdata;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    new_guess_reg <= half_sat;
                    step_reg      <= step_reg + nsr_pkg::STEP_W'(1);
                end
            end
            ST_CHECK: guess_reg <= new_guess_reg;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            out_root_reg <= (|guess_reg[nsr_pkg::GUESS_W-1:nsr_pkg::ROOT_W])
                            ? nsr_pkg::ROOT_MAX : guess_reg[nsr_pkg::ROOT_W-1:0];
            out_inv_reg  <= inv_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_root_reg;
    assign m_tuser  = out_inv_reg;

endmodule

// ===== src/nsr_checker.sv =====
// ----------------------------------------------------------------------------
// nsr_checker
// Port-level checks for the Newton square root core, bound to the top level.
// ----------------------------------------------------------------------------
module nsr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // an invalid result carries a zero root
    a_inv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 24'd0)
        else $error("invalid result with nonzero root");

    // the core goes busy after taking a word
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while busy");

    // a negative word that finds the output free is flagged once the done state loads the output register
    a_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[31] && (!m_tvalid || m_tready)
        |=> ##1 m_tvalid && m_tuser)
        else $error("negative word not flagged invalid");

endmodule

bind newton_square_root_core nsr_checker u_nsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
